@@ hdl/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants for the source character tokenizer
// Beat payloads, token kind and error codes, keyword spellings and the
// character class decoders.
// ----------------------------------------------------------------------------
package sct_pkg;

	// width of the token position fields on the result channel
	localparam int unsigned FIELD_BITS = 24;

	// depth of the result queue: one item may push three results at once
	localparam int unsigned RES_DEPTH = 4;

	// token kinds, in the order the downstream parser expects
	typedef enum logic [5:0] {
		TK_END, TK_IDENT, TK_INTEGER,
		TK_FN, TK_LET, TK_VAR, TK_RETURN, TK_IF, TK_ELSE, TK_WHILE, TK_TRUE,
		TK_FALSE, TK_PRINT,
		TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_COMMA, TK_COLON,
		TK_SEMI, TK_ARROW, TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_PERCENT,
		TK_ASSIGN, TK_BANG, TK_NE, TK_EQ, TK_LT, TK_LE, TK_GT, TK_GE,
		TK_ANDAND, TK_OROR
	} tok_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_UNEXPECTED,
		ERR_MISSING_SECOND
	} err_code_t;

	// keyword spellings, first character in the low byte
	localparam int unsigned NUM_KEYWORDS = 10;
	localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
		64'h0000_0000_0000_6e66,  // fn
		64'h0000_0000_0074_656c,  // let
		64'h0000_0000_0072_6176,  // var
		64'h0000_6e72_7574_6572,  // return
		64'h0000_0000_0000_6669,  // if
		64'h0000_0000_6573_6c65,  // else
		64'h0000_0065_6c69_6877,  // while
		64'h0000_0000_6575_7274,  // true
		64'h0000_0065_736c_6166,  // false
		64'h0000_0074_6e69_7270   // print
	};
	localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
		4'd2, 4'd3, 4'd3, 4'd6, 4'd2, 4'd4, 4'd5, 4'd4, 4'd5, 4'd5
	};

	localparam logic [7:0] CH_CR = 8'h0D;

	// input beat
	typedef struct packed {
		logic [7:0] char_code;
		logic       char_present;
		logic       end_of_source;
	} char_item_t;

	// result beat
	typedef struct packed {
		logic [5:0]            token_kind;
		logic [1:0]            error_code;
		logic [FIELD_BITS-1:0] token_line;
		logic [FIELD_BITS-1:0] start_offset;
		logic [FIELD_BITS-1:0] lexeme_length;
		logic                  last_of_run;
	} token_item_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || c == "\t" || c == CH_CR;
	endfunction

	// punctuation that is always one character
	function automatic tok_kind_t single_kind(input logic [7:0] c);
		tok_kind_t k;
		unique case (c)
			"(": k = TK_LPAREN;
			")": k = TK_RPAREN;
			"{": k = TK_LBRACE;
			"}": k = TK_RBRACE;
			",": k = TK_COMMA;
			":": k = TK_COLON;
			";": k = TK_SEMI;
			"+": k = TK_PLUS;
			"*": k = TK_STAR;
			"%": k = TK_PERCENT;
			default: k = TK_END;
		endcase
		return k;
	endfunction

	// operators that may take a second character, as a lone character
	function automatic tok_kind_t alone_kind(input logic [7:0] c);
		tok_kind_t k;
		unique case (c)
			"-": k = TK_MINUS;
			"/": k = TK_SLASH;
			"=": k = TK_ASSIGN;
			"!": k = TK_BANG;
			"<": k = TK_LT;
			">": k = TK_GT;
			default: k = TK_END;
		endcase
		return k;
	endfunction

	// two-character operators
	function automatic tok_kind_t pair_kind(input logic [7:0] p, input logic [7:0] c);
		tok_kind_t k;
		k = TK_END;
		if (p == "-" && c == ">") k = TK_ARROW;
		if (p == "!" && c == "=") k = TK_NE;
		if (p == "=" && c == "=") k = TK_EQ;
		if (p == "<" && c == "=") k = TK_LE;
		if (p == ">" && c == "=") k = TK_GE;
		if (p == "&" && c == "&") k = TK_ANDAND;
		if (p == "|" && c == "|") k = TK_OROR;
		return k;
	endfunction

endpackage

@@ hdl/sct_stream_if.sv @@
// ----------------------------------------------------------------------------
// sct_stream_if: valid/ready stream channel
// Carries one beat of payload type T; a beat moves when valid and ready are
// both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface sct_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/source_char_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_char_tokenizer: streaming lexer for source text
// Scans one byte per beat and emits tokens with line, offset and length.
// ----------------------------------------------------------------------------
// Usage:
//   chars  : one source byte per beat (sct_pkg::char_item_t). A beat with
//            end_of_source set closes the source; its byte, if present, is
//            scanned first. A bare beat (no byte, no end) only releases a
//            held End token.
//   tokens : result beats (sct_pkg::token_item_t); last_of_run marks the
//            final result caused by one input beat.
// Throughput: one input beat per cycle unless stalled. Scanning is a single
//   combinational pass from the scan registers into a four-entry result queue;
//   chars.ready is high while the queue holds at most one result, so a beat
//   that makes one or zero results never stalls an undisturbed stream.
// Results: a result enters the result queue when its beat is accepted and is
//   driven on tokens from the queue head. A beat that would yield four results
//   keeps the End token back and releases it first with the next input beat.
// Reset: arst_n clears the queue and returns the scanner to line 1, byte 0.
// Stall: while tokens.ready is low results queue up; input is held off
//   once fewer than three queue entries are free.
// ----------------------------------------------------------------------------
module source_char_tokenizer
	import sct_pkg::*;
#(
	parameter int unsigned COUNTER_BITS         = 24,
	parameter int unsigned KEYWORD_WINDOW_CHARS = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	sct_stream_if.sink   chars,
	sct_stream_if.source tokens
);

	localparam int unsigned CW   = COUNTER_BITS;
	localparam int unsigned WINW = 8 * KEYWORD_WINDOW_CHARS;
	localparam int unsigned PTRW = $clog2(RES_DEPTH);
	localparam int unsigned CNTW = $clog2(RES_DEPTH + 1);
	localparam int unsigned NCAND = 5;

	// scan modes
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_WORD    = 3'd1;
	localparam logic [2:0] MODE_DIGITS  = 3'd2;
	localparam logic [2:0] MODE_OPER    = 3'd3;
	localparam logic [2:0] MODE_COMMENT = 3'd4;

	typedef struct packed {
		tok_kind_t   kind;
		err_code_t   err;
		logic [CW-1:0] line;
		logic [CW-1:0] off;
		logic [CW-1:0] len;
	} cand_t;

	// ------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------
	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [WINW-1:0] grow_win(input logic [WINW-1:0] w,
			input logic [CW-1:0] tl, input logic [7:0] c);
		logic [WINW-1:0] r;
		r = w;
		for (int j = 0; j < KEYWORD_WINDOW_CHARS; j++) begin
			if (tl == CW'(j)) r[8*j +: 8] = c;
		end
		return r;
	endfunction

	function automatic tok_kind_t word_kind(input logic [WINW-1:0] w,
			input logic [CW-1:0] tl);
		logic [63:0] w64;
		tok_kind_t   k;
		w64 = '0;
		w64[WINW-1:0] = w;
		k = TK_IDENT;
		for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
			if (tl == CW'(KW_LEN[i]) && w64 == KW_TEXT[i])
				k = tok_kind_t'(6'(TK_FN) + 6'(i));
		end
		return k;
	endfunction

	function automatic cand_t mk(input tok_kind_t k, input err_code_t e,
			input logic [CW-1:0] ln, input logic [CW-1:0] of,
			input logic [CW-1:0] le);
		cand_t r;
		r.kind = k;
		r.err  = e;
		r.line = ln;
		r.off  = of;
		r.len  = le;
		return r;
	endfunction

	function automatic logic [FIELD_BITS-1:0] to_field(input logic [CW-1:0] v);
		logic [CW+FIELD_BITS-1:0] e;
		e = {{FIELD_BITS{1'b0}}, v};
		return e[FIELD_BITS-1:0];
	endfunction

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	logic [2:0]      mode_q;
	logic [7:0]      pend_q;
	logic [WINW-1:0] win_q;
	logic [CW-1:0]   tstart_q, tlen_q, bpos_q, line_q;
	logic            halt_q;
	logic            owed_q;
	logic [CW-1:0]   owed_line_q, owed_off_q;

	token_item_t     fifo_q [RES_DEPTH];
	logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] count_q;

	// ------------------------------------------------------------------
	// next scan state and result candidates
	// ------------------------------------------------------------------
	logic [2:0]      mode_d;
	logic [7:0]      pend_d;
	logic [WINW-1:0] win_d;
	logic [CW-1:0]   tstart_d, tlen_d, bpos_d, line_d;
	logic            halt_d, used;
	tok_kind_t       pk, sk;
	logic [7:0]      c;
	cand_t           cand [NCAND];
	logic [NCAND-1:0] cvld;
	cand_t           comp [NCAND];
	logic [2:0]      ncomp;
	logic [1:0]      npush;
	logic            owed_d;

	assign c = chars.data.char_code;

	always_comb begin
		mode_d   = mode_q;
		pend_d   = pend_q;
		win_d    = win_q;
		tstart_d = tstart_q;
		tlen_d   = tlen_q;
		bpos_d   = bpos_q;
		line_d   = line_q;
		halt_d   = halt_q;
		used     = 1'b0;
		pk       = pair_kind(pend_q, c);
		sk       = single_kind(c);
		for (int i = 0; i < NCAND; i++) cand[i] = '0;
		cvld     = '0;

		// End held back from the previous beat goes first
		cvld[0] = owed_q;
		cand[0] = mk(TK_END, ERR_NONE, owed_line_q, owed_off_q, '0);

		if (chars.data.char_present && !halt_q) begin
			// continue or close the open token
			unique case (mode_q)
				MODE_WORD: begin
					if (is_alpha(c) || is_digit(c) || c == "_") begin
						win_d  = grow_win(win_q, tlen_q, c);
						tlen_d = sat_inc(tlen_q);
						used   = 1'b1;
					end else begin
						cvld[1] = 1'b1;
						cand[1] = mk(word_kind(win_q, tlen_q), ERR_NONE, line_q,
							tstart_q, tlen_q);
						mode_d  = MODE_IDLE;
					end
				end
				MODE_DIGITS: begin
					if (is_digit(c)) begin
						win_d  = grow_win(win_q, tlen_q, c);
						tlen_d = sat_inc(tlen_q);
						used   = 1'b1;
					end else begin
						cvld[1] = 1'b1;
						cand[1] = mk(TK_INTEGER, ERR_NONE, line_q, tstart_q, tlen_q);
						mode_d  = MODE_IDLE;
					end
				end
				MODE_OPER: begin
					mode_d = MODE_IDLE;
					if (pend_q == "/" && c == "/") begin
						mode_d = MODE_COMMENT;
						used   = 1'b1;
					end else if (pk != TK_END) begin
						cvld[1] = 1'b1;
						cand[1] = mk(pk, ERR_NONE, line_q, tstart_q, CW'(2));
						used    = 1'b1;
					end else if (pend_q == "&" || pend_q == "|") begin
						cvld[1] = 1'b1;
						cand[1] = mk((pend_q == "&") ? TK_ANDAND : TK_OROR,
							ERR_MISSING_SECOND, line_q, tstart_q, CW'(1));
						halt_d  = 1'b1;
						used    = 1'b1;
					end else begin
						cvld[1] = 1'b1;
						cand[1] = mk(alone_kind(pend_q), ERR_NONE, line_q, tstart_q,
							CW'(1));
					end
				end
				MODE_COMMENT: begin
					used = 1'b1;
					if (c == "\n") begin
						line_d = sat_inc(line_q);
						mode_d = MODE_IDLE;
					end
				end
				default: mode_d = MODE_IDLE;
			endcase

			// byte not consumed: start something new
			if (!used) begin
				if (is_blank(c)) begin
					// skip
				end else if (c == "\n") begin
					line_d = sat_inc(line_q);
				end else if (is_alpha(c) || c == "_" || is_digit(c)) begin
					mode_d   = is_digit(c) ? MODE_DIGITS : MODE_WORD;
					tstart_d = bpos_q;
					win_d    = grow_win('0, '0, c);
					tlen_d   = CW'(1);
				end else if (sk != TK_END) begin
					cvld[2] = 1'b1;
					cand[2] = mk(sk, ERR_NONE, line_q, bpos_q, CW'(1));
				end else if (alone_kind(c) != TK_END || c == "&" || c == "|") begin
					mode_d   = MODE_OPER;
					tstart_d = bpos_q;
					win_d    = grow_win('0, '0, c);
					tlen_d   = CW'(1);
					pend_d   = c;
				end else begin
					cvld[2] = 1'b1;
					cand[2] = mk(TK_END, ERR_UNEXPECTED, line_q, bpos_q, CW'(1));
					halt_d  = 1'b1;
				end
			end
			bpos_d = sat_inc(bpos_q);
		end

		// end of source: flush, End unless halted, then back to the start of a source
		if (chars.data.end_of_source) begin
			if (!halt_d) begin
				unique case (mode_d)
					MODE_WORD: begin
						cvld[3] = 1'b1;
						cand[3] = mk(word_kind(win_d, tlen_d), ERR_NONE, line_d,
							tstart_d, tlen_d);
					end
					MODE_DIGITS: begin
						cvld[3] = 1'b1;
						cand[3] = mk(TK_INTEGER, ERR_NONE, line_d, tstart_d, tlen_d);
					end
					MODE_OPER: begin
						cvld[3] = 1'b1;
						if (pend_d == "&" || pend_d == "|") begin
							cand[3] = mk((pend_d == "&") ? TK_ANDAND : TK_OROR,
								ERR_MISSING_SECOND, line_d, tstart_d, CW'(1));
							halt_d  = 1'b1;
						end else begin
							cand[3] = mk(alone_kind(pend_d), ERR_NONE, line_d,
								tstart_d, CW'(1));
						end
					end
					default: ;
				endcase
				cvld[4] = !halt_d;
				cand[4] = mk(TK_END, ERR_NONE, line_d, bpos_d, '0);
			end
			mode_d   = MODE_IDLE;
			pend_d   = '0;
			win_d    = '0;
			tstart_d = '0;
			tlen_d   = '0;
			bpos_d   = '0;
			line_d   = CW'(1);
			halt_d   = 1'b0;
		end

		// pack the candidates in order
		for (int i = 0; i < NCAND; i++) comp[i] = '0;
		ncomp = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cvld[i]) begin
				comp[ncomp] = cand[i];
				ncomp       = ncomp + 1'b1;
			end
		end
		owed_d = (ncomp > 3'd3);
		npush  = owed_d ? 2'd3 : ncomp[1:0];
	end

	// ------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------
	logic accept, pop;
	logic [CNTW-1:0] push_cnt, pop_cnt;

	assign chars.ready  = (count_q <= CNTW'(RES_DEPTH - 3));
	assign accept       = chars.valid && chars.ready;
	assign tokens.valid = (count_q != '0);
	assign tokens.data  = fifo_q[rd_ptr_q];
	assign pop          = tokens.valid && tokens.ready;
	assign push_cnt     = accept ? CNTW'(npush) : '0;
	assign pop_cnt      = pop ? CNTW'(1) : '0;

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			pend_q      <= '0;
			win_q       <= '0;
			tstart_q    <= '0;
			tlen_q      <= '0;
			bpos_q      <= '0;
			line_q      <= CW'(1);
			halt_q      <= 1'b0;
			owed_q      <= 1'b0;
			owed_line_q <= '0;
			owed_off_q  <= '0;
		end else if (accept) begin
			mode_q      <= mode_d;
			pend_q      <= pend_d;
			win_q       <= win_d;
			tstart_q    <= tstart_d;
			tlen_q      <= tlen_d;
			bpos_q      <= bpos_d;
			line_q      <= line_d;
			halt_q      <= halt_d;
			owed_q      <= owed_d;
			owed_line_q <= comp[3].line;
			owed_off_q  <= comp[3].off;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTRW'(push_cnt);
			rd_ptr_q <= rd_ptr_q + PTRW'(pop_cnt);
			count_q  <= count_q + push_cnt - pop_cnt;
		end
	end

	// result queue entries
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < npush) begin
					fifo_q[wr_ptr_q + PTRW'(k)] <= '{
						token_kind:    comp[k].kind,
						error_code:    comp[k].err,
						token_line:    to_field(comp[k].line),
						start_offset:  to_field(comp[k].off),
						lexeme_length: to_field(comp[k].len),
						last_of_run:   (2'(k) == npush - 2'd1)
					};
				end
			end
		end
	end

endmodule

@@ tb/tb_source_char_tokenizer.sv @@
// ----------------------------------------------------------------------------
// tb_source_char_tokenizer: self-checking bench for the source tokenizer
// Drives source bytes on the chars channel and checks every token beat against
// an in-bench lexer model, or a pinned row's own token. A short table of directed
// beats comes first, then random programs that are mostly well formed with some
// noise, under changing idle patterns on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_source_char_tokenizer;
	import sct_pkg::*;

	localparam int unsigned COUNT_TOP    = 24'hFFFFFF;
	localparam int unsigned BURST_MAX    = 3;
	localparam int unsigned WINDOW_CHARS = 6;
	localparam int          RANDOM_ITEMS = 420;
	localparam int          LONG_HOLD    = 80;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          REPORT_MAX   = 10;

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_WORD, SCAN_DIGITS, SCAN_OPER, SCAN_COMMENT
	} scan_mode_t;

	typedef struct {
		char_item_t  item;
		bit          pinned;
		token_item_t want;
	} vector_row_t;

	logic clk;
	logic arst_n;

	sct_stream_if #(.T(char_item_t))  chars_if ();
	sct_stream_if #(.T(token_item_t)) tokens_if ();

	source_char_tokenizer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tokens_if)
	);

	// directed beats; a pinned row carries the one token it must produce
	vector_row_t dir_rows [25] = '{
		'{'{"(", 1'b1, 1'b0}, 1'b1, '{TK_LPAREN, ERR_NONE, 24'd1, 24'd0, 24'd1, 1'b1}},
		'{'{"\n", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"f", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"n", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"&", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"&", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"|", 1'b1, 1'b0}, 1'b0, '0},
		'{'{";", 1'b1, 1'b0}, 1'b1,
			'{TK_OROR, ERR_MISSING_SECOND, 24'd2, 24'd6, 24'd1, 1'b1}},
		'{'{8'h00, 1'b0, 1'b1}, 1'b0, '0},
		'{'{8'h00, 1'b1, 1'b0}, 1'b1,
			'{TK_END, ERR_UNEXPECTED, 24'd1, 24'd0, 24'd1, 1'b1}},
		'{'{8'h00, 1'b0, 1'b1}, 1'b0, '0},
		'{'{8'hFF, 1'b1, 1'b0}, 1'b1,
			'{TK_END, ERR_UNEXPECTED, 24'd1, 24'd0, 24'd1, 1'b1}},
		'{'{"x", 1'b1, 1'b1}, 1'b0, '0},
		'{'{"1", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"2", 1'b1, 1'b0}, 1'b0, '0},
		'{'{">", 1'b1, 1'b1}, 1'b0, '0},
		'{'{"x", 1'b1, 1'b0}, 1'b0, '0},
		'{'{";", 1'b1, 1'b1}, 1'b0, '0},
		'{'{"/", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"/", 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'h80, 1'b1, 1'b0}, 1'b0, '0},
		'{'{"\n", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"-", 1'b1, 1'b1}, 1'b0, '0},
		'{'{8'h5A, 1'b0, 1'b0}, 1'b0, '0},
		'{'{8'h00, 1'b0, 1'b1}, 1'b1, '{TK_END, ERR_NONE, 24'd1, 24'd0, 24'd0, 1'b1}}
	};

	string kw_spell [10] = '{
		"fn", "let", "var", "return", "if", "else", "while", "true", "false", "print"
	};
	string op_spell [23] = '{
		"(", ")", "{", "}", ",", ":", ";", "+", "-", "*", "/", "%", "=", "!", "<", ">",
		"->", "==", "!=", "<=", ">=", "&&", "||"
	};
	// first 53 characters may start a word
	string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

	// lexer model state
	scan_mode_t  scan;
	logic [7:0]  held_op;
	logic [47:0] word_head;
	int unsigned tok_start;
	int unsigned tok_len;
	int unsigned byte_pos;
	int unsigned line_no;
	bit          halted;
	bit          end_owed;
	int unsigned owed_line;
	int unsigned owed_pos;

	token_item_t step_tokens [$];
	token_item_t tokens_due [$];
	logic [7:0]  src_text [$];

	int  send_idle_pct;
	int  recv_idle_pct;
	int  bad_beats;
	int  cycle_count;
	int  fed;
	int  phase;
	int  hold_left;
	bit  hold_request;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// lexer model
	// ------------------------------------------------------------------------
	function automatic int unsigned bump(input int unsigned v);
		return (v < COUNT_TOP) ? v + 1 : v;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return c inside {["a":"z"], ["A":"Z"]};
	endfunction

	function automatic bit is_numeral(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic tok_kind_t punct_kind(input logic [7:0] c);
		case (c)
			"(": return TK_LPAREN;
			")": return TK_RPAREN;
			"{": return TK_LBRACE;
			"}": return TK_RBRACE;
			",": return TK_COMMA;
			":": return TK_COLON;
			";": return TK_SEMI;
			"+": return TK_PLUS;
			"*": return TK_STAR;
			"%": return TK_PERCENT;
			default: return TK_END;
		endcase
	endfunction

	function automatic tok_kind_t lone_kind(input logic [7:0] c);
		case (c)
			"-": return TK_MINUS;
			"/": return TK_SLASH;
			"=": return TK_ASSIGN;
			"!": return TK_BANG;
			"<": return TK_LT;
			">": return TK_GT;
			default: return TK_END;
		endcase
	endfunction

	function automatic tok_kind_t combo_kind(input logic [7:0] p, input logic [7:0] c);
		case ({p, c})
			"->": return TK_ARROW;
			"!=": return TK_NE;
			"==": return TK_EQ;
			"<=": return TK_LE;
			">=": return TK_GE;
			"&&": return TK_ANDAND;
			"||": return TK_OROR;
			default: return TK_END;
		endcase
	endfunction

	function automatic void put_token(input tok_kind_t k, input err_code_t e,
		input int unsigned ln, input int unsigned off, input int unsigned len);
		token_item_t t;
		t.token_kind    = k;
		t.error_code    = e;
		t.token_line    = FIELD_BITS'(ln);
		t.start_offset  = FIELD_BITS'(off);
		t.lexeme_length = FIELD_BITS'(len);
		t.last_of_run   = 1'b0;
		step_tokens.insert(step_tokens.size(), t);
	endfunction

	function automatic void extend(input logic [7:0] c);
		if (tok_len < WINDOW_CHARS) word_head[8*tok_len +: 8] = c;
		tok_len = bump(tok_len);
	endfunction

	function automatic void open_token(input scan_mode_t m, input logic [7:0] c);
		scan      = m;
		tok_start = byte_pos;
		tok_len   = 0;
		word_head = '0;
		extend(c);
	endfunction

	// keyword when the whole word sits in the window and spells one
	function automatic tok_kind_t word_kind();
		bit hit;
		for (int i = 0; i < 10; i++) begin
			if (tok_len == kw_spell[i].len()) begin
				hit = 1'b1;
				for (int j = 0; j < kw_spell[i].len(); j++)
					if (word_head[8*j +: 8] != kw_spell[i][j]) hit = 1'b0;
				if (hit) return tok_kind_t'(TK_FN + i);
			end
		end
		return TK_IDENT;
	endfunction

	function automatic void scan_char(input logic [7:0] c);
		bit        taken;
		tok_kind_t k;
		taken = 1'b0;
		// finish or extend the token in progress
		case (scan)
			SCAN_WORD: begin
				if (is_letter(c) || is_numeral(c) || c == "_") begin
					extend(c);
					taken = 1'b1;
				end else begin
					put_token(word_kind(), ERR_NONE, line_no, tok_start, tok_len);
					scan = SCAN_IDLE;
				end
			end
			SCAN_DIGITS: begin
				if (is_numeral(c)) begin
					extend(c);
					taken = 1'b1;
				end else begin
					put_token(TK_INTEGER, ERR_NONE, line_no, tok_start, tok_len);
					scan = SCAN_IDLE;
				end
			end
			SCAN_OPER: begin
				k    = combo_kind(held_op, c);
				scan = SCAN_IDLE;
				if (held_op == "/" && c == "/") begin
					scan  = SCAN_COMMENT;
					taken = 1'b1;
				end else if (k != TK_END) begin
					put_token(k, ERR_NONE, line_no, tok_start, 2);
					taken = 1'b1;
				end else if (held_op == "&" || held_op == "|") begin
					put_token((held_op == "&") ? TK_ANDAND : TK_OROR, ERR_MISSING_SECOND,
						line_no, tok_start, 1);
					halted = 1'b1;
					taken  = 1'b1;
				end else begin
					put_token(lone_kind(held_op), ERR_NONE, line_no, tok_start, 1);
				end
			end
			SCAN_COMMENT: begin
				taken = 1'b1;
				if (c == "\n") begin
					line_no = bump(line_no);
					scan    = SCAN_IDLE;
				end
			end
			default: scan = SCAN_IDLE;
		endcase
		// byte not absorbed: start whatever it begins
		if (!taken) begin
			if (c == " " || c == "\t" || c == CH_CR) begin
			end else if (c == "\n") begin
				line_no = bump(line_no);
			end else if (is_letter(c) || c == "_") begin
				open_token(SCAN_WORD, c);
			end else if (is_numeral(c)) begin
				open_token(SCAN_DIGITS, c);
			end else if (punct_kind(c) != TK_END) begin
				put_token(punct_kind(c), ERR_NONE, line_no, byte_pos, 1);
			end else if (lone_kind(c) != TK_END || c == "&" || c == "|") begin
				open_token(SCAN_OPER, c);
				held_op = c;
			end else begin
				put_token(TK_END, ERR_UNEXPECTED, line_no, byte_pos, 1);
				halted = 1'b1;
			end
		end
		byte_pos = bump(byte_pos);
	endfunction

	// flush the open token at end of source, then the End token unless halted
	function automatic void close_source();
		case (scan)
			SCAN_WORD: put_token(word_kind(), ERR_NONE, line_no, tok_start, tok_len);
			SCAN_DIGITS: put_token(TK_INTEGER, ERR_NONE, line_no, tok_start, tok_len);
			SCAN_OPER: begin
				if (held_op == "&" || held_op == "|") begin
					put_token((held_op == "&") ? TK_ANDAND : TK_OROR, ERR_MISSING_SECOND,
						line_no, tok_start, 1);
					halted = 1'b1;
				end else begin
					put_token(lone_kind(held_op), ERR_NONE, line_no, tok_start, 1);
				end
			end
			default: ;
		endcase
		if (!halted) put_token(TK_END, ERR_NONE, line_no, byte_pos, 0);
	endfunction

	function automatic void restart_scan();
		scan      = SCAN_IDLE;
		held_op   = '0;
		word_head = '0;
		tok_start = 0;
		tok_len   = 0;
		byte_pos  = 0;
		line_no   = 1;
		halted    = 1'b0;
	endfunction

	// tokens caused by one accepted beat, left in step_tokens
	function automatic void tokenize_item(input char_item_t it);
		step_tokens.delete();
		if (end_owed) begin
			put_token(TK_END, ERR_NONE, owed_line, owed_pos, 0);
			end_owed = 1'b0;
		end
		if (it.char_present && !halted) scan_char(it.char_code);
		if (it.end_of_source) begin
			if (!halted) close_source();
			restart_scan();
		end
		// a fourth token is held back for the next beat
		if (step_tokens.size() > BURST_MAX) begin
			end_owed  = 1'b1;
			owed_line = 32'(step_tokens[BURST_MAX].token_line);
			owed_pos  = 32'(step_tokens[BURST_MAX].start_offset);
			while (step_tokens.size() > BURST_MAX) step_tokens.delete(step_tokens.size() - 1);
		end
		if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic send_item(input char_item_t it, input bit pinned, input token_item_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.data  <= it;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		tokenize_item(it);
		if (pinned) tokens_due.insert(tokens_due.size(), want);
		else foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
	endtask

	// stop offering and wait for every outstanding token
	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (tokens_due.size() != 0) @(posedge clk);
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) src_text.insert(src_text.size(), s[i]);
	endfunction

	// random program text: mostly tokens and blanks, a little noise
	function automatic void compose_source();
		int target;
		int pick;
		int n;
		src_text.delete();
		target = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(4, 40);
		while (src_text.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				add_text(kw_spell[$urandom_range(0, 9)]);
			end else if (pick < 32) begin
				// identifier, sometimes a keyword with a tail
				if ($urandom_range(0, 3) == 0) add_text(kw_spell[$urandom_range(0, 9)]);
				else src_text.insert(src_text.size(), word_chars[$urandom_range(0, 52)]);
				n = $urandom_range(0, 8);
				repeat (n) src_text.insert(src_text.size(), word_chars[$urandom_range(0, 62)]);
			end else if (pick < 42) begin
				n = $urandom_range(1, 6);
				repeat (n) src_text.insert(src_text.size(), 8'("0" + $urandom_range(0, 9)));
			end else if (pick < 64) begin
				add_text(op_spell[$urandom_range(0, 22)]);
			end else if (pick < 74) begin
				add_text(($urandom_range(0, 2) == 0) ? "\t" :
					($urandom_range(0, 1) == 0) ? "\r" : " ");
			end else if (pick < 80) begin
				add_text("\n");
			end else if (pick < 85) begin
				add_text("//");
				n = $urandom_range(0, 10);
				repeat (n) src_text.insert(src_text.size(), 8'($urandom_range(32, 126)));
				if ($urandom_range(0, 4) != 0) add_text("\n");
			end else if (pick < 88) begin
				src_text.insert(src_text.size(), 8'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				add_text(($urandom_range(0, 1) == 0) ? "&" : "|");
			end else begin
				add_text(" ");
			end
			if ($urandom_range(0, 1) == 0) add_text(" ");
		end
	endfunction

	// one program as beats, closed by its last byte or a bare end beat
	task automatic send_source();
		bit         eos_on_last;
		char_item_t it;
		eos_on_last = (src_text.size() > 0) && ($urandom_range(0, 1) == 1);
		foreach (src_text[i]) begin
			if ($urandom_range(0, 19) == 0) begin
				it.char_code     = 8'($urandom_range(0, 255));
				it.char_present  = 1'b0;
				it.end_of_source = 1'b0;
				send_item(it, 1'b0, '0);
				fed++;
			end
			it.char_code     = src_text[i];
			it.char_present  = 1'b1;
			it.end_of_source = eos_on_last && (i == src_text.size() - 1);
			send_item(it, 1'b0, '0);
			fed++;
		end
		if (!eos_on_last) begin
			it.char_code     = 8'($urandom_range(0, 255));
			it.char_present  = 1'b0;
			it.end_of_source = 1'b1;
			send_item(it, 1'b0, '0);
			fed++;
		end
	endtask

	initial begin
		chars_if.valid  <= 1'b0;
		chars_if.data   <= '0;
		tokens_if.ready <= 1'b0;
		arst_n          <= 1'b0;
		send_idle_pct = 12;
		recv_idle_pct = 52;
		bad_beats     = 0;
		fed           = 0;
		phase         = 1;
		hold_request  = 1'b0;
		end_owed      = 1'b0;
		restart_scan();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].want);

		while (fed < RANDOM_ITEMS) begin
			// idle pattern changes at each third of the run
			if (phase == 1 && fed >= RANDOM_ITEMS / 3) begin
				wait_drained();
				send_idle_pct = 52;
				recv_idle_pct = 12;
				phase         = 2;
			end else if (phase == 2 && fed >= 2 * RANDOM_ITEMS / 3) begin
				wait_drained();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_request  = 1'b1;
				phase         = 3;
			end
			compose_source();
			send_source();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (bad_beats == 0) begin
			$display("PASS source_char_tokenizer");
		end else begin
			$display("FAIL source_char_tokenizer");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// token sink and checker
	// ------------------------------------------------------------------------
	task automatic note_mismatch(input string what, input token_item_t want,
		input token_item_t got);
		bad_beats++;
		if (bad_beats <= REPORT_MAX) begin
			$display("token mismatch (%s): expected kind %0d err %0d line %0d off %0d len %0d last %0d",
				what, want.token_kind, want.error_code, want.token_line, want.start_offset,
				want.lexeme_length, want.last_of_run);
			$display("  got kind %0d err %0d line %0d off %0d len %0d last %0d",
				got.token_kind, got.error_code, got.token_line, got.start_offset,
				got.lexeme_length, got.last_of_run);
		end
	endtask

	initial begin
		token_item_t want;
		token_item_t got;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (tokens_if.valid && tokens_if.ready) begin
				got = tokens_if.data;
				if (tokens_due.size() == 0) begin
					note_mismatch("nothing expected", '0, got);
				end else begin
					want = tokens_due.pop_front();
					if (got.token_kind !== want.token_kind ||
						got.error_code !== want.error_code ||
						got.token_line !== want.token_line ||
						got.start_offset !== want.start_offset ||
						got.lexeme_length !== want.lexeme_length ||
						got.last_of_run !== want.last_of_run)
						note_mismatch("field", want, got);
				end
			end
			// long hold-off lets the result queue fill and block input
			if (hold_request) begin
				hold_left    = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				tokens_if.ready <= 1'b0;
				hold_left--;
			end else begin
				tokens_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL source_char_tokenizer");
		$finish;
	end

endmodule
